// ===== design/scgm_pkg.sv =====
// ----------------------------------------------------------------------------
// scgm_pkg
// Shared types and constants for the segmented character-to-glyph map.
// ----------------------------------------------------------------------------
package scgm_pkg;

    localparam int MAX_SEGMENTS      = 256;
    localparam int GLYPH_ARRAY_WORDS = 1024;

    localparam int SEG_AW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int GLY_AW  = (GLYPH_ARRAY_WORDS > 1) ? $clog2(GLYPH_ARRAY_WORDS) : 1;
    localparam int COUNT_W = 9;
    localparam int WORD_W  = 16;
    localparam int INDEX_W = 10;
    localparam int IDX_W   = 19;

    localparam logic [1:0] REQ_LOAD_SEG   = 2'd0;
    localparam logic [1:0] REQ_LOAD_GLYPH = 2'd1;
    localparam logic [1:0] REQ_LOOKUP     = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SEGMENT = 2'd1;
    localparam logic [1:0] ST_RANGE      = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [INDEX_W-1:0] entry_index;
        logic [WORD_W-1:0]  start_code;
        logic [WORD_W-1:0]  end_code;
        logic [WORD_W-1:0]  id_delta;
        logic [WORD_W-1:0]  range_offset;
        logic [WORD_W-1:0]  glyph_word;
        logic [WORD_W-1:0]  char_code;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] glyph_id;
        logic [1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0] start_code;
        logic [WORD_W-1:0] end_code;
        logic [WORD_W-1:0] id_delta;
        logic [WORD_W-1:0] range_offset;
    } seg_t;

endpackage

// ===== design/scgm_req_if.sv =====
// ----------------------------------------------------------------------------
// scgm_req_if
// Request channel: load and lookup words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scgm_req_if;
    logic          valid;
    logic          ready;
    scgm_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/scgm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// scgm_rsp_if
// Response channel: glyph index and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface scgm_rsp_if;
    logic          valid;
    logic          ready;
    scgm_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/scgm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// scgm_cfg_if
// Configuration write channel carrying the segment count.
// ----------------------------------------------------------------------------
interface scgm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [scgm_pkg::COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/segmented_char_to_glyph_map.sv =====
// ----------------------------------------------------------------------------
// segmented_char_to_glyph_map
// Segmented 16-bit character code to glyph index map with table loading.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one word per handshake: a segment load, a glyph array word
//   load, or a code lookup. Loads write the segment or glyph memory and give
//   no response. A lookup gives one rsp word (glyph_id,
//   status). cfg writes the segment count; write it only while idle.
// Scan:
//   The segments are scanned in order, one compare per cycle through the
//   segment memory read port. A hit that needs a glyph array read waits
//   in S_GWAIT for it; a miss scans all n segments, n being the saturated
//   segment count. req.ready is high between lookups.
// Reset:
//   Clears control state and sets the segment count to 1. Memory contents
//   are undefined until loaded; no clearing pass is run.
// Stall:
//   A finished response waits in the output register; loads and the next
//   lookup are still taken, and a lookup holds at its end until rsp drains.
// ----------------------------------------------------------------------------
module segmented_char_to_glyph_map (
    input  logic        clk,
    input  logic        rst_n,
    scgm_req_if.sink    req,
    scgm_rsp_if.source  rsp,
    scgm_cfg_if.sink    cfg
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_CALC  = 5'b00100,
        S_GWAIT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam int SEG_W = $bits(scgm_pkg::seg_t);
    localparam int WW    = scgm_pkg::WORD_W;
    localparam int CW    = scgm_pkg::COUNT_W;
    localparam int XW    = scgm_pkg::IDX_W;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              n_reg, n_next;
    logic [CW-1:0]              issue_k_reg, issue_k_next;
    logic                       chk_valid_reg, chk_valid_next;
    logic [CW-1:0]              chk_k_reg, chk_k_next;
    logic [CW-1:0]              hit_k_reg, hit_k_next;
    scgm_pkg::seg_t             hit_seg_reg, hit_seg_next;
    logic [WW-1:0]              code_reg, code_next;
    scgm_pkg::rsp_t             res_reg, res_next;
    logic                       out_valid_reg, out_valid_next;
    scgm_pkg::rsp_t             out_data_reg, out_data_next;

    logic                       req_acc;
    logic                       seg_wr_en;
    logic                       gly_wr_en;
    logic                       seg_rd_en;
    logic                       gly_rd_en;
    logic [SEG_W-1:0]           seg_rd_raw;
    scgm_pkg::seg_t             seg_rd;
    logic [WW-1:0]              gly_rd;
    logic                       seg_hit;
    logic [XW-1:0]              idx;
    logic                       idx_bad;
    logic                       out_free;
    logic [CW-1:0]              n_sat;

    assign req_acc   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign seg_wr_en = req_acc && (req.data.req_type == scgm_pkg::REQ_LOAD_SEG)
                       && (32'(req.data.entry_index) < scgm_pkg::MAX_SEGMENTS);
    assign gly_wr_en = req_acc && (req.data.req_type == scgm_pkg::REQ_LOAD_GLYPH)
                       && (32'(req.data.entry_index) < scgm_pkg::GLYPH_ARRAY_WORDS);

    assign n_sat = (32'(count_reg) > scgm_pkg::MAX_SEGMENTS)
                   ? CW'(scgm_pkg::MAX_SEGMENTS) : count_reg;

    assign seg_rd  = scgm_pkg::seg_t'(seg_rd_raw);
    assign seg_hit = chk_valid_reg && (code_reg >= seg_rd.start_code)
                     && (code_reg <= seg_rd.end_code);
    assign seg_rd_en = (state_reg == S_SCAN) && !seg_hit && (issue_k_reg < n_reg);

    assign idx = XW'(hit_k_reg) + XW'(hit_seg_reg.range_offset[WW-1:1]) + XW'(code_reg)
                 - XW'(hit_seg_reg.start_code) - XW'(n_reg);
    assign idx_bad = idx[XW-1] || (idx >= XW'(scgm_pkg::GLYPH_ARRAY_WORDS));
    assign gly_rd_en = (state_reg == S_CALC) && (hit_seg_reg.range_offset != '0) && !idx_bad;

    scgm_ram #(
        .WIDTH (SEG_W),
        .DEPTH (scgm_pkg::MAX_SEGMENTS)
    ) u_seg_ram (
        .clk     (clk),
        .wr_en   (seg_wr_en),
        .wr_addr (scgm_pkg::SEG_AW'(req.data.entry_index)),
        .wr_data ({req.data.start_code, req.data.end_code,
                   req.data.id_delta, req.data.range_offset}),
        .rd_en   (seg_rd_en),
        .rd_addr (scgm_pkg::SEG_AW'(issue_k_reg)),
        .rd_data (seg_rd_raw)
    );

    scgm_ram #(
        .WIDTH (WW),
        .DEPTH (scgm_pkg::GLYPH_ARRAY_WORDS)
    ) u_glyph_ram (
        .clk     (clk),
        .wr_en   (gly_wr_en),
        .wr_addr (scgm_pkg::GLY_AW'(req.data.entry_index)),
        .wr_data (req.data.glyph_word),
        .rd_en   (gly_rd_en),
        .rd_addr (scgm_pkg::GLY_AW'(idx)),
        .rd_data (gly_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        issue_k_next   = issue_k_reg;
        chk_valid_next = chk_valid_reg;
        chk_k_next     = chk_k_reg;
        hit_k_next     = hit_k_reg;
        hit_seg_next   = hit_seg_reg;
        code_next      = code_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_acc && (req.data.req_type == scgm_pkg::REQ_LOOKUP))
                begin
                    code_next      = req.data.char_code;
                    n_next         = n_sat;
                    issue_k_next   = '0;
                    chk_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (seg_hit)
                begin
                    hit_k_next     = chk_k_reg;
                    hit_seg_next   = seg_rd;
                    chk_valid_next = 1'b0;
                    state_next     = S_CALC;
                end
                else if (seg_rd_en)
                begin
                    chk_valid_next = 1'b1;
                    chk_k_next     = issue_k_reg;
                    issue_k_next   = issue_k_reg + 1'b1;
                end
                else if (!chk_valid_reg)
                begin
                    res_next.glyph_id = '0;
                    res_next.status   = scgm_pkg::ST_NO_SEGMENT;
                    state_next        = S_DONE;
                end
                else
                begin
                    chk_valid_next = 1'b0;
                end
            end
            S_CALC:
            begin
                if (hit_seg_reg.range_offset == '0)
                begin
                    res_next.glyph_id = hit_seg_reg.id_delta + code_reg;
                    res_next.status   = scgm_pkg::ST_OK;
                    state_next        = S_DONE;
                end
                else if (idx_bad)
                begin
                    res_next.glyph_id = '0;
                    res_next.status   = scgm_pkg::ST_RANGE;
                    state_next        = S_DONE;
                end
                else
                begin
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                res_next.glyph_id = (gly_rd != '0) ? (gly_rd + hit_seg_reg.id_delta) : '0;
                res_next.status   = scgm_pkg::ST_OK;
                state_next        = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CW'(1);
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            issue_k_reg   <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            issue_k_reg   <= issue_k_next;
            n_reg         <= n_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        chk_k_reg    <= chk_k_next;
        hit_k_reg    <= hit_k_next;
        hit_seg_reg  <= hit_seg_next;
        code_reg     <= code_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    a_lookup_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_acc && (req.data.req_type == scgm_pkg::REQ_LOOKUP)) |=> (state_reg == S_SCAN))
        else $error("lookup did not start a segment scan");

    a_check_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (chk_valid_reg && (state_reg == S_SCAN)) |-> (chk_k_reg < n_reg))
        else $error("segment compared beyond the segment count");

    a_glyph_read_follows_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GWAIT) |-> $past(gly_rd_en))
        else $error("glyph wait without a glyph array read");

    a_done_holds_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_valid_reg && !rsp.ready) |=> (state_reg == S_DONE))
        else $error("response overwrote a waiting output word");

endmodule

// ===== design/scgm_ram.sv =====
// ----------------------------------------------------------------------------
// scgm_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scgm_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the segmented character-to-glyph map. A mirror of the
// segment table and glyph array predicts every lookup response. A short
// directed sequence runs first. Random phases follow, each at a new segment
// count and with random segments, some with start and end swapped. Lookups
// load an unwritten glyph word they read first. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import scgm_pkg::*;

    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS   = 90;
    localparam int PHASES        = 12;
    localparam int PHASE_COUNTS [PHASES] = '{0, 1, 2, 5, 16, 256, 511, 300, 9, 64, 3, 1};

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    class cmap_mirror;
        bit [WORD_W-1:0]  seg_start    [MAX_SEGMENTS];
        bit [WORD_W-1:0]  seg_end      [MAX_SEGMENTS];
        bit [WORD_W-1:0]  seg_delta    [MAX_SEGMENTS];
        bit [WORD_W-1:0]  seg_offset   [MAX_SEGMENTS];
        bit               seg_loaded   [MAX_SEGMENTS];
        bit [WORD_W-1:0]  glyphs       [GLYPH_ARRAY_WORDS];
        bit               glyph_loaded [GLYPH_ARRAY_WORDS];
        bit [COUNT_W-1:0] count;
        rsp_t             pending_glyphs [$];
        int               mismatches;

        function new();
            count      = 1;
            mismatches = 0;
        endfunction

        function int searched();
            return (count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(count);
        endfunction

        function int find_segment(bit [WORD_W-1:0] code);
            for (int k = 0; k < searched(); k++)
                if (code >= seg_start[k] && code <= seg_end[k])
                    return k;
            return -1;
        endfunction

        function int glyph_slot(int k, bit [WORD_W-1:0] code);
            return k + int'(seg_offset[k] >> 1) + int'(code) - int'(seg_start[k]) - searched();
        endfunction

        function int missing_glyph(bit [WORD_W-1:0] code);
            int k;
            int idx;
            k = find_segment(code);
            if (k < 0 || seg_offset[k] == 0)
                return -1;
            idx = glyph_slot(k, code);
            if (idx >= 0 && idx < GLYPH_ARRAY_WORDS && !glyph_loaded[idx])
                return idx;
            return -1;
        endfunction

        function rsp_t predict(bit [WORD_W-1:0] code);
            rsp_t r;
            int   k;
            int   idx;
            r.glyph_id = '0;
            r.status   = ST_NO_SEGMENT;
            k = find_segment(code);
            if (k < 0)
                return r;
            r.status = ST_OK;
            if (seg_offset[k] == 0)
            begin
                r.glyph_id = seg_delta[k] + code;
                return r;
            end
            idx = glyph_slot(k, code);
            if (idx < 0 || idx >= GLYPH_ARRAY_WORDS)
            begin
                r.status = ST_RANGE;
                return r;
            end
            if (glyphs[idx] != 0)
                r.glyph_id = glyphs[idx] + seg_delta[k];
            return r;
        endfunction

        function void note_request(req_t it);
            case (it.req_type)
                REQ_LOAD_SEG:
                begin
                    if (it.entry_index < MAX_SEGMENTS)
                    begin
                        seg_start[it.entry_index]  = it.start_code;
                        seg_end[it.entry_index]    = it.end_code;
                        seg_delta[it.entry_index]  = it.id_delta;
                        seg_offset[it.entry_index] = it.range_offset;
                        seg_loaded[it.entry_index] = 1'b1;
                    end
                end
                REQ_LOAD_GLYPH:
                begin
                    if (it.entry_index < GLYPH_ARRAY_WORDS)
                    begin
                        glyphs[it.entry_index]       = it.glyph_word;
                        glyph_loaded[it.entry_index] = 1'b1;
                    end
                end
                REQ_LOOKUP:
                    pending_glyphs.push_back(predict(it.char_code));
                default:
                    ;
            endcase
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_glyphs.size() == 0)
            begin
                $error("unexpected response: glyph_id %0d status %0d", got.glyph_id, got.status);
                mismatches++;
                return;
            end
            want = pending_glyphs.pop_front();
            if (got.glyph_id !== want.glyph_id)
            begin
                $error("glyph_id: expected %0d, actual %0d", want.glyph_id, got.glyph_id);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   req_calm;
    bit   rsp_calm;
    int unsigned cycle_count;

    cmap_mirror book = new();

    scgm_req_if req();
    scgm_rsp_if rsp();
    scgm_cfg_if cfg();

    segmented_char_to_glyph_map u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_top failed");
        $finish;
    end

    initial
    begin : drain_responses
        int gap;
        gap = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp.valid && rsp.ready)
                begin
                    book.check_result(rsp.data);
                    gap = rsp_calm ? 0 : $urandom_range(0, 4);
                end
                else if (gap > 0)
                    gap--;
                rsp.ready <= (gap == 0);
            end
        end
    end

    function automatic req_t random_word();
        req_t r;
        r.req_type     = 2'($urandom);
        r.entry_index  = 10'($urandom);
        r.start_code   = 16'($urandom);
        r.end_code     = 16'($urandom);
        r.id_delta     = 16'($urandom);
        r.range_offset = 16'($urandom);
        r.glyph_word   = 16'($urandom);
        r.char_code    = 16'($urandom);
        return r;
    endfunction

    // Offsets aim into the glyph array for the count n of the current phase.
    function automatic req_t make_segment(int k, int n);
        req_t            r;
        int              span;
        int              base;
        bit [WORD_W-1:0] tmp;
        r             = random_word();
        r.req_type    = REQ_LOAD_SEG;
        r.entry_index = 10'(k);
        span = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
        r.start_code = 16'($urandom_range(0, 65535 - span));
        r.end_code   = r.start_code + 16'(span);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                r.range_offset = '0;
            4, 5, 6, 7, 8:
            begin
                base = (span < GLYPH_ARRAY_WORDS) ? $urandom_range(0, GLYPH_ARRAY_WORDS - 1 - span) : 0;
                r.range_offset = 16'(2 * (n - k + base) + $urandom_range(0, 1));
            end
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    tmp          = r.start_code;
                    r.start_code = r.end_code;
                    r.end_code   = tmp;
                end
            end
        endcase
        return r;
    endfunction

    function automatic bit [WORD_W-1:0] pick_code(int n);
        int k;
        if (n > 0 && $urandom_range(0, 9) < 7)
        begin
            k = $urandom_range(0, n - 1);
            if (book.seg_end[k] >= book.seg_start[k])
                return book.seg_start[k]
                    + 16'($urandom_range(0, book.seg_end[k] - book.seg_start[k]));
            return book.seg_start[k];
        end
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input req_t it);
        int gap;
        gap = req_calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= it;
        do @(posedge clk); while (!req.ready);
        book.note_request(it);
    endtask

    task automatic load_segment(input int k, input bit [WORD_W-1:0] first,
                                input bit [WORD_W-1:0] last, input bit [WORD_W-1:0] delta,
                                input bit [WORD_W-1:0] offset);
        req_t it;
        it              = random_word();
        it.req_type     = REQ_LOAD_SEG;
        it.entry_index  = 10'(k);
        it.start_code   = first;
        it.end_code     = last;
        it.id_delta     = delta;
        it.range_offset = offset;
        send_item(it);
    endtask

    task automatic load_glyph(input int idx, input bit [WORD_W-1:0] value);
        req_t it;
        it             = random_word();
        it.req_type    = REQ_LOAD_GLYPH;
        it.entry_index = 10'(idx);
        it.glyph_word  = value;
        send_item(it);
    endtask

    task automatic send_unused();
        req_t it;
        it          = random_word();
        it.req_type = REQ_UNUSED;
        send_item(it);
    endtask

    // Load the glyph word a lookup will read first, if it was never written.
    task automatic do_lookup(input bit [WORD_W-1:0] code);
        req_t it;
        int   slot;
        slot = book.missing_glyph(code);
        if (slot >= 0)
            load_glyph(slot, ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom));
        it           = random_word();
        it.req_type  = REQ_LOOKUP;
        it.char_code = code;
        send_item(it);
    endtask

    task automatic go_quiet();
        req.valid <= 1'b0;
        while (book.pending_glyphs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_count(input bit [COUNT_W-1:0] n);
        go_quiet();
        cfg.data  <= n;
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        book.count = n;
    endtask

    task automatic run_directed();
        load_segment(0, 16'h0041, 16'h005A, 16'hFFFF, 16'h0000);
        do_lookup(16'h0041);
        do_lookup(16'h005A);
        do_lookup(16'h0040);
        do_lookup(16'hFFFF);
        send_unused();
        load_segment(1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        do_lookup(16'h0041);
        load_segment(0, 16'h0000, 16'hFFFF, 16'h0010, 16'd13);
        load_glyph(5, 16'hFFFF);
        do_lookup(16'd0);
        load_glyph(7, 16'h0000);
        do_lookup(16'd2);
        load_glyph(1023, 16'h1234);
        do_lookup(16'd1018);
        do_lookup(16'd1019);
        do_lookup(16'hFFFF);
        load_segment(0, 16'h0100, 16'h01FF, 16'h0000, 16'd1);
        do_lookup(16'h0100);
        do_lookup(16'h0101);
        do_lookup(16'h0000);
    endtask

    task automatic run_phase(input int count, input int items);
        int   n;
        int   done;
        int   roll;
        req_t it;
        n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
        for (int k = 0; k < n; k++)
            if (!book.seg_loaded[k])
                send_item(make_segment(k, n));
        write_count(COUNT_W'(count));
        req_calm = ($urandom_range(0, 3) == 0);
        rsp_calm = ($urandom_range(0, 3) == 0);
        done = 0;
        while (done < items)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                do_lookup(pick_code(n));
            else if (roll < 70)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    it             = random_word();
                    it.req_type    = REQ_LOAD_SEG;
                    it.entry_index = 10'($urandom_range(MAX_SEGMENTS, 1023));
                    send_item(it);
                end
                else
                    send_item(make_segment($urandom_range(0, (n > 0) ? n - 1 : 0), n));
            end
            else if (roll < 88)
                load_glyph($urandom_range(0, GLYPH_ARRAY_WORDS - 1),
                           ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom));
            else
            begin
                send_unused();
                done--;
            end
            done++;
        end
    endtask

    initial
    begin : stimulus
        rst_n = 1'b0;
        req_calm = 1'b0;
        rsp_calm = 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        cfg.valid <= 1'b0;
        cfg.data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        foreach (PHASE_COUNTS[i])
            run_phase(PHASE_COUNTS[i], PHASE_ITEMS);
        go_quiet();
        if (book.mismatches == 0 && book.pending_glyphs.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
